// File: rtl/fixed_sine_cosine_lut_interp_assert.svh
// Assertion macros for the sine/cosine interpolator.
`ifndef FIXED_SINE_COSINE_LUT_INTERP_ASSERT_SVH
`define FIXED_SINE_COSINE_LUT_INTERP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define FSC_ASSERT_NOW(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define FSC_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// File: rtl/fsc_pkg.sv
// Shared types, constants and the quarter-wave ROM generator.
package fsc_pkg;

    // Field widths
    localparam int ANGLE_W = 16;
    localparam int VALUE_W = 10;
    localparam int ENTRY_W = 9;
    localparam int TDATA_IN_W  = 16;
    localparam int TDATA_OUT_W = 16;

    // Kind codes
    typedef enum logic {
        KIND_SINE   = 1'b0,
        KIND_COSINE = 1'b1
    } kind_t;

    // Q30 constants for the ROM polynomial
    localparam longint unsigned Q30_ONE     = 64'd1 << 30;
    localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
    localparam longint unsigned B_Q30 = (Q30_ONE * 64'd166592) / 64'd1000000
                                      + (Q30_ONE * 64'd452584) / 64'd1000000000000;

    // Entry i of the quarter-wave table, trunc(256*sin(t)) via a fifth-order polynomial
    function automatic logic [ENTRY_W-1:0] rom_entry(input int unsigned idx,
                                                     input int unsigned idx_bits);
        longint unsigned t;
        longint unsigned s;
        longint unsigned as_term;
        longint unsigned v;
        longint unsigned u;
        longint unsigned p;
        longint unsigned sq;
        t       = (64'(idx) * PI_HALF_Q30) >> idx_bits;
        s       = (t * t) >> 30;
        as_term = (s * 64'd8091) / 64'd1000000
                + (s * 64'd67377688) / 64'd100000000000000;
        v       = B_Q30 - as_term;
        u       = (s * v) >> 30;
        p       = Q30_ONE - u;
        sq      = (t * p) >> 30;
        return ENTRY_W'((sq * 64'd256) >> 30);
    endfunction

endpackage

// File: rtl/fsc_fold.sv
// Angle folding: cosine offset, sign, quadrant and mirrored fraction.
module fsc_fold #(
    parameter int FRACTION_BITS = 8
) (
    input  fsc_pkg::kind_t                      kind,
    input  logic signed [fsc_pkg::ANGLE_W-1:0]  angle,
    output logic                                neg,
    output logic [FRACTION_BITS:0]              frac
);
    import fsc_pkg::*;

    localparam int X_W = ANGLE_W + 1;
    localparam logic signed [X_W-1:0] QUAD_UNITS = X_W'(1 << FRACTION_BITS);
    localparam logic [FRACTION_BITS:0] FULL_FRAC = (FRACTION_BITS + 1)'(1 << FRACTION_BITS);

    logic signed [X_W-1:0] x;
    logic        [X_W-1:0] mag;
    logic [FRACTION_BITS:0] frac_raw;

    // Cosine is the sine of one quadrant minus the angle, at full width
    assign x = (kind == KIND_COSINE) ? (QUAD_UNITS - X_W'(angle)) : X_W'(angle);

    // Sign and magnitude
    assign mag = x[X_W-1] ? X_W'(-x) : X_W'(x);

    // Odd quadrants mirror, quadrants two and three flip the sign
    assign frac_raw = {1'b0, mag[FRACTION_BITS-1:0]};
    assign frac = mag[FRACTION_BITS] ? (FULL_FRAC - frac_raw) : frac_raw;
    assign neg  = x[X_W-1] ^ mag[FRACTION_BITS+1];

endmodule

// File: rtl/fsc_quarter_lut.sv
// Quarter-wave ROM lookup with linear interpolation between neighbor entries.
module fsc_quarter_lut #(
    parameter int TABLE_INDEX_BITS = 4,
    parameter int FRACTION_BITS    = 8
) (
    input  logic [FRACTION_BITS:0]          frac,
    output logic [fsc_pkg::ENTRY_W-1:0]     mag
);
    import fsc_pkg::*;

    localparam int BS        = (FRACTION_BITS > TABLE_INDEX_BITS) ?
                               FRACTION_BITS - TABLE_INDEX_BITS : 0;
    localparam int US        = (TABLE_INDEX_BITS > FRACTION_BITS) ?
                               TABLE_INDEX_BITS - FRACTION_BITS : 0;
    localparam int IDX_W     = TABLE_INDEX_BITS + 1;
    localparam int ROM_DEPTH = (1 << TABLE_INDEX_BITS) + 1;
    localparam int WIDE_W    = FRACTION_BITS + US + 1;
    localparam int OFF_W     = (BS > 0) ? BS : 1;
    localparam int SUM_W     = ENTRY_W + OFF_W + 2;
    localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(1 << TABLE_INDEX_BITS);
    localparam logic [OFF_W:0]    BIN      = (OFF_W + 1)'(1 << BS);

    logic [ENTRY_W-1:0] rom [0:ROM_DEPTH-1];
    logic [WIDE_W-1:0]  idx_wide;
    logic [IDX_W-1:0]   idx_lo;
    logic [IDX_W-1:0]   idx_hi;
    logic [OFF_W-1:0]   off;
    logic [OFF_W:0]     w_lo;
    logic [SUM_W-1:0]   sum;

    // Constant table, one entry per index
    for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_rom
        assign rom[g] = rom_entry(g, TABLE_INDEX_BITS);
    end

    // Table index from the upper fraction bits, held at the last entry
    assign idx_wide = (WIDE_W'(frac) >> BS) << US;
    assign idx_lo   = (idx_wide > WIDE_W'(IDX_LAST)) ? IDX_LAST : idx_wide[IDX_W-1:0];
    assign idx_hi   = (idx_lo == IDX_LAST) ? IDX_LAST : idx_lo + IDX_W'(1);

    // Offset inside the bin, zero when there is no interpolation
    assign off  = (BS > 0) ? frac[OFF_W-1:0] : '0;
    assign w_lo = BIN - (OFF_W + 1)'(off);

    // Weighted sum of the two neighbors, truncated by the bin width
    assign sum = SUM_W'(off) * SUM_W'(rom[idx_hi]) + SUM_W'(w_lo) * SUM_W'(rom[idx_lo]);
    assign mag = (off == '0) ? rom[idx_lo] : ENTRY_W'(sum >> BS);

endmodule

// File: rtl/fixed_sine_cosine_lut_interp.sv
// Top level of the streaming sine/cosine interpolator.
// Sine or cosine of a signed angle (4 * 2^FRACTION_BITS units per turn, 1024 at the
// default) as signed Q8 in m_tdata[9:0], 256 meaning one. s_tuser selects the
// function (0 sine, 1 cosine). Each item is registered in the input register and
// then moves to the result register unless a waiting result is stalled; its result is
// offered on m_tvalid from the result register and is taken while m_tready is high.
// One item is taken per clock while the output side keeps up; the only
// stall is a waiting result while the input register also holds an item. The fold,
// constant-table read and two-tap interpolation sit between those two registers.
`include "fixed_sine_cosine_lut_interp_assert.svh"

module fixed_sine_cosine_lut_interp #(
    parameter int TABLE_INDEX_BITS = 4,
    parameter int FRACTION_BITS    = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [fsc_pkg::TDATA_IN_W-1:0]      s_tdata,   // [15:0] angle
    input  logic                                s_tuser,   // [0] kind
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [fsc_pkg::TDATA_OUT_W-1:0]     m_tdata    // [9:0] value, [15:10] zero
);
    import fsc_pkg::*;

    logic                        in_valid_reg, in_valid_next;
    kind_t                       in_kind_reg;
    logic signed [ANGLE_W-1:0]   in_angle_reg;
    logic                        out_valid_reg, out_valid_next;
    logic signed [VALUE_W-1:0]   out_value_reg;
    logic                        stall;
    logic                        take;
    logic                        neg;
    logic [FRACTION_BITS:0]      frac;
    logic [ENTRY_W-1:0]          mag;
    logic signed [VALUE_W-1:0]   value;

    // Handshake: the pipe halts only while a result waits downstream
    assign stall    = out_valid_reg && !m_tready;
    assign s_tready = !in_valid_reg || !stall;
    assign take     = s_tvalid && s_tready;

    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (!stall) begin
            out_valid_next = in_valid_reg;
            in_valid_next  = take;
        end else if (take) begin
            in_valid_next = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input item register
    always_ff @(posedge aclk) begin
        if (take) begin
            in_kind_reg  <= kind_t'(s_tuser);
            in_angle_reg <= $signed(s_tdata[ANGLE_W-1:0]);
        end
    end

    fsc_fold #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_fold (
        .kind (in_kind_reg),
        .angle(in_angle_reg),
        .neg  (neg),
        .frac (frac)
    );

    fsc_quarter_lut #(
        .TABLE_INDEX_BITS(TABLE_INDEX_BITS),
        .FRACTION_BITS   (FRACTION_BITS)
    ) u_lut (
        .frac(frac),
        .mag (mag)
    );

    // Apply the sign; a negative zero stays zero
    assign value = neg ? -$signed(VALUE_W'(mag)) : $signed(VALUE_W'(mag));

    // Result register
    always_ff @(posedge aclk) begin
        if (!stall && in_valid_reg) begin
            out_value_reg <= value;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_OUT_W'($unsigned(out_value_reg));

    // Checks
    `FSC_ASSERT_NEXT(a_hold_in_item, aclk, aresetn, in_valid_reg && stall, in_valid_reg && $stable(in_angle_reg), "input item lost during stall")
    `FSC_ASSERT_NOW(a_ready_when_empty, aclk, aresetn, !in_valid_reg, s_tready, "not ready with empty input register")
    `FSC_ASSERT_NOW(a_value_range, aclk, aresetn, m_tvalid, ($signed(m_tdata[9:0]) <= 10'sd256) && ($signed(m_tdata[9:0]) >= -10'sd256), "result outside Q8 range")
    `FSC_ASSERT_NEXT(a_result_follows, aclk, aresetn, in_valid_reg && !stall, m_tvalid, "result register missed an item")

endmodule

// File: tb/sv/fixed_sine_cosine_lut_interp_tb.sv
// Self-checking testbench for the streaming sine/cosine interpolator.
module fixed_sine_cosine_lut_interp_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fsc_pkg::*;

    localparam int IDX_BITS    = 4;
    localparam int FRAC_BITS   = 8;
    localparam int BIN_BITS    = FRAC_BITS - IDX_BITS;
    localparam int QUAD_UNITS  = 1 << FRAC_BITS;
    localparam int LAST_ENTRY  = 1 << IDX_BITS;
    localparam int RAND_ITEMS  = 700;
    localparam int DRAIN_WAIT  = 8;
    localparam int CYCLE_LIMIT = 400000;

    // One pending result: the item that caused it and the value it should carry
    typedef struct {
        kind_t               kind;
        logic signed [15:0]  angle;
        logic [VALUE_W-1:0]  value;
    } sincos_expect_t;

    // Holds predicted values in order and compares them with what comes out
    class sincos_expectations;
        int unsigned     quarter_wave[LAST_ENTRY + 1];
        sincos_expect_t  pending_values[$];
        int              errors;

        function new();
            longint unsigned one_q30;
            longint unsigned half_pi;
            longint unsigned cubic;
            longint unsigned t;
            longint unsigned s;
            longint unsigned quintic;
            longint unsigned poly;
            longint unsigned prod;
            one_q30 = 64'd1 << 30;
            half_pi = 64'd1686629713;
            cubic = (one_q30 * 64'd166592) / 64'd1000000
                  + (one_q30 * 64'd452584) / 64'd1000000000000;
            errors = 0;
            // Fifth-order sine polynomial in Q30, truncated at every product
            for (int i = 0; i <= LAST_ENTRY; i++) begin
                t = (longint'(i) * half_pi) >> IDX_BITS;
                s = (t * t) >> 30;
                quintic = (s * 64'd8091) / 64'd1000000
                        + (s * 64'd67377688) / 64'd100000000000000;
                poly = one_q30 - ((s * (cubic - quintic)) >> 30);
                prod = (t * poly) >> 30;
                quarter_wave[i] = int'((prod * 64'd256) >> 30);
            end
        endfunction

        // Fold the angle into the first quadrant and interpolate between two entries
        function logic [VALUE_W-1:0] fold_and_interp(kind_t kind, logic signed [15:0] angle);
            int x;
            int mag;
            int quad;
            int frac;
            int idx;
            int off;
            int val;
            bit neg;
            x = (kind == KIND_COSINE) ? QUAD_UNITS - int'(angle) : int'(angle);
            neg = x < 0;
            mag = neg ? -x : x;
            quad = mag >> FRAC_BITS;
            frac = mag & (QUAD_UNITS - 1);
            // odd quadrants mirror, quadrants 2 and 3 flip the sign
            if (quad % 2 == 1)
                frac = QUAD_UNITS - frac;
            if ((quad / 2) % 2 == 1)
                neg = !neg;
            idx = frac >> BIN_BITS;
            off = frac & ((1 << BIN_BITS) - 1);
            if (idx > LAST_ENTRY)
                idx = LAST_ENTRY;
            if (off == 0)
                val = quarter_wave[idx];
            else
                val = (off * quarter_wave[idx + 1]
                      + ((1 << BIN_BITS) - off) * quarter_wave[idx]) >> BIN_BITS;
            if (neg)
                val = -val;
            return val[VALUE_W-1:0];
        endfunction

        function void note_angle(kind_t kind, logic signed [15:0] angle);
            sincos_expect_t e;
            e.kind = kind;
            e.angle = angle;
            e.value = fold_and_interp(kind, angle);
            pending_values.push_back(e);
        endfunction

        function void check_value(logic [VALUE_W-1:0] actual);
            sincos_expect_t e;
            if (pending_values.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0d",
                         $realtime, $signed(actual));
                errors++;
                return;
            end
            e = pending_values.pop_front();
            if (actual !== e.value) begin
                $display("%0t: value mismatch (kind %0d angle %0d), expected %0d, actual %0d",
                         $realtime, e.kind, e.angle, $signed(e.value), $signed(actual));
                errors++;
            end
        endfunction
    endclass

    logic                    aclk;
    logic                    aresetn;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [TDATA_IN_W-1:0]   s_tdata;    // [15:0] angle
    logic                    s_tuser;    // [0] kind
    logic                    m_tvalid;
    logic                    m_tready;
    logic [TDATA_OUT_W-1:0]  m_tdata;    // [9:0] value, [15:10] zero

    int                  send_idle_pct;
    int                  recv_idle_pct;
    longint              cycles = 0;
    sincos_expectations  book = new();

    fixed_sine_cosine_lut_interp #(
        .TABLE_INDEX_BITS(IDX_BITS),
        .FRACTION_BITS(FRAC_BITS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Watch both channels; items are predicted as they are accepted
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                book.check_value(m_tdata[VALUE_W-1:0]);
            if (s_tvalid && s_tready)
                book.note_angle(kind_t'(s_tuser), s_tdata);
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side back-pressure
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready = aresetn && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Present one item, with random idle cycles ahead of it
    task automatic drive_angle(input kind_t kind, input logic [15:0] angle);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = angle;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Half the angles within two turns either way, plus full range, quadrant edges, bin edges and extremes
    function automatic logic [15:0] pick_angle();
        int sel;
        sel = $urandom_range(9);
        case (sel)
            0, 1, 2, 3, 4: begin
                return 16'($urandom_range(4095) - 2048);
            end
            5, 6: begin
                return 16'($urandom);
            end
            7: begin
                return 16'(($urandom_range(63) - 32) * QUAD_UNITS + $urandom_range(2) - 1);
            end
            8: begin
                return 16'(($urandom_range(511) - 256) * (1 << BIN_BITS));
            end
            default: begin
                return $urandom_range(1) ? 16'(32767 - $urandom_range(300))
                                         : 16'(-32768 + $urandom_range(300));
            end
        endcase
    endfunction

    // Stimulus
    initial begin
        logic signed [15:0] edge_angles[12];
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        aresetn  = 1'b0;
        send_idle_pct = 28;
        recv_idle_pct = 55;
        edge_angles = '{0, 1, -1, 8, 16, 255, 256, 512, -768, 1024, 32767, -32768};
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;

        // directed: quadrant edges, mirrored full fraction, negative zero, extremes
        foreach (edge_angles[i]) begin
            drive_angle(KIND_SINE, edge_angles[i]);
            drive_angle(KIND_COSINE, edge_angles[i]);
        end

        // random, in three idling phases
        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                send_idle_pct = 55;
                recv_idle_pct = 28;
            end else if (phase == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int n = 0; n < RAND_ITEMS / 3; n++)
                drive_angle(kind_t'($urandom_range(1)), pick_angle());
        end
        s_tvalid = 1'b0;

        // drain
        while (book.pending_values.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (book.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/fsc_pkg.sv
rtl/fsc_fold.sv
rtl/fsc_quarter_lut.sv
rtl/fixed_sine_cosine_lut_interp.sv
tb/sv/fixed_sine_cosine_lut_interp_tb.sv
